// File: sv/assert_macros.svh
// Assertion macros shared by the view matrix transform RTL.
// Included by the modules that carry assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define VMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/vmt_pkg.sv
// Shared types, constants and elaboration-time sine/cosine functions for the
// view matrix transform unit. No dependencies.
package vmt_pkg;

  localparam int ANGLE_STEPS_DEF   = 3600;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TENTHS_PER_TURN   = 3600;
  localparam int ANGLE_W           = 12;
  localparam int ELEM_W            = 32;
  localparam int TAYLOR_TERMS      = 14;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam longint unsigned SIN_DIV [TAYLOR_TERMS] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812};
  localparam longint unsigned COS_DIV [TAYLOR_TERMS] =
    '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756};

  localparam logic [3:0] LOCAL_LAST = 4'd5;
  localparam logic [3:0] FULL_LAST  = 4'd15;
  localparam logic [1:0] LAST_ROW   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOCAL  = 2'd0,
    OP_WORLD  = 2'd1,
    OP_ROTATE = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    B_ONE  = 3'd0,
    B_COS  = 3'd1,
    B_SIN  = 3'd2,
    B_NSIN = 3'd3,
    B_MV0  = 3'd4,
    B_MV1  = 3'd5,
    B_MV2  = 3'd6
  } bsel_t;

  typedef struct packed {
    logic       valid;
    logic       a_one;
    logic [3:0] a_idx;
    bsel_t      b_sel;
    logic       first;
    logic       last;
    logic [3:0] dest;
  } term_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [3:0] dest;
  } mac_tag_t;

  typedef struct packed {
    logic              en;
    logic [3:0]        addr;
    logic [ELEM_W-1:0] data;
  } mat_wr_t;

  typedef struct packed {
    logic       load;
    logic [1:0] row;
  } emit_t;

  // Sine and cosine of t (Q30, first quadrant) by a truncating Taylor series.
  function automatic logic [63:0] taylor_q30(longint unsigned t);
    longint unsigned t2;
    longint unsigned ts;
    longint unsigned tc;
    longint          ss;
    longint          cs;
    t2 = (t * t) >> 30;
    ts = t;
    tc = Q30_ONE;
    ss = $signed(t);
    cs = $signed(Q30_ONE);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      ts = ((ts * t2) >> 30) / SIN_DIV[n];
      tc = ((tc * t2) >> 30) / COS_DIV[n];
      if (n % 2 == 0) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    return {ss[31:0], cs[31:0]};
  endfunction

  // Rounds a Q30 value half away from zero to frac fraction bits.
  function automatic logic signed [31:0] q30_to_fix(logic signed [31:0] v, int unsigned frac);
    longint unsigned mag;
    longint unsigned r;
    int unsigned     sh;
    sh  = 30 - frac;
    mag = v[31] ? 64'(-longint'(v)) : 64'(longint'(v));
    r   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[31] ? -32'(r) : 32'(r);
  endfunction

endpackage

// File: sv/vmt_sincos_rom.sv
// Sine/cosine table indexed by angle in tenths of a degree, registered read.
// Entries are built at elaboration with the functions of vmt_pkg.
module vmt_sincos_rom #(
  parameter int ANGLE_STEPS   = vmt_pkg::ANGLE_STEPS_DEF,
  parameter int FRACTION_BITS = vmt_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic [vmt_pkg::ANGLE_W-1:0]        addr,
  output logic signed [vmt_pkg::ELEM_W-1:0]  sin_q,
  output logic signed [vmt_pkg::ELEM_W-1:0]  cos_q
);

  localparam int TURN = vmt_pkg::TENTHS_PER_TURN;

  wire [2*vmt_pkg::ELEM_W-1:0] rom_tbl [0:TURN];
  logic [2*vmt_pkg::ELEM_W-1:0] rom_q_r;

  for (genvar g = 0; g <= TURN; g++) begin : g_entry
    localparam longint unsigned IDX  = (64'(g) * ANGLE_STEPS) / TURN;
    localparam longint unsigned QUAD = ((4 * IDX) / ANGLE_STEPS) % 4;
    localparam longint unsigned REM  = (4 * IDX) % ANGLE_STEPS;
    localparam longint unsigned T    =
      (vmt_pkg::HALF_PI_Q30 * REM + ANGLE_STEPS / 2) / ANGLE_STEPS;
    localparam logic [63:0]        BASE = vmt_pkg::taylor_q30(T);
    localparam logic signed [31:0] BS   = BASE[63:32];
    localparam logic signed [31:0] BC   = BASE[31:0];
    localparam logic signed [31:0] RS   =
      (QUAD == 0) ? BS : (QUAD == 1) ? BC : (QUAD == 2) ? -BS : -BC;
    localparam logic signed [31:0] RC   =
      (QUAD == 0) ? BC : (QUAD == 1) ? -BS : (QUAD == 2) ? -BC : BS;
    assign rom_tbl[g] = {vmt_pkg::q30_to_fix(RS, FRACTION_BITS),
                         vmt_pkg::q30_to_fix(RC, FRACTION_BITS)};
  end

  always_ff @(posedge clk) begin
    if (addr <= vmt_pkg::ANGLE_W'(TURN)) begin
      rom_q_r <= rom_tbl[addr];
    end else begin
      rom_q_r <= '0;
    end
  end

  assign sin_q = rom_q_r[2*vmt_pkg::ELEM_W-1:vmt_pkg::ELEM_W];
  assign cos_q = rom_q_r[vmt_pkg::ELEM_W-1:0];

endmodule

// File: sv/vmt_mac.sv
// Shared multiply-accumulate unit: operand stage, product stage, then a
// floor shift, accumulate and saturating matrix write. Uses vmt_pkg.
module vmt_mac #(
  parameter int FRACTION_BITS = vmt_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vmt_pkg::mac_tag_t                 tag,
  input  logic signed [vmt_pkg::ELEM_W-1:0] op_a,
  input  logic signed [vmt_pkg::ELEM_W-1:0] op_b,
  output vmt_pkg::mat_wr_t                  wr
);

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  vmt_pkg::mac_tag_t s1_r;
  vmt_pkg::mac_tag_t s2_r;
  logic signed [vmt_pkg::ELEM_W-1:0] op_a_r;
  logic signed [vmt_pkg::ELEM_W-1:0] op_b_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] acc_nxt;
  logic signed [63:0] base;
  logic signed [63:0] term_fl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= tag;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r <= op_a;
    op_b_r <= op_b;
    prod_r <= 64'(op_a_r) * 64'(op_b_r);
    if (s2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    term_fl = prod_r >>> FRACTION_BITS;
    base    = s2_r.first ? 64'sd0 : acc_r;
    acc_nxt = base + term_fl;
    wr.en   = s2_r.valid && s2_r.last;
    wr.addr = s2_r.dest;
    if (acc_nxt > SAT_MAX) begin
      wr.data = 32'h7FFF_FFFF;
    end else if (acc_nxt < SAT_MIN) begin
      wr.data = 32'h8000_0000;
    end else begin
      wr.data = acc_nxt[31:0];
    end
  end

endmodule

// File: sv/vmt_seq.sv
// Sequencer: input and output handshakes, axis walk, and the term schedule
// that feeds the shared multiply-accumulate unit. Uses vmt_pkg and the macros.
`include "assert_macros.svh"

module vmt_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [2:0]            angle_nz,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            axis,
  output vmt_pkg::term_t        term,
  output vmt_pkg::emit_t        emit
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_AXIS  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  localparam logic [1:0] AXIS_DONE  = 2'd3;
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t            state_r, state_nxt;
  vmt_pkg::opcode_t  op_r, op_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [3:0]        term_r, term_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [1:0]        row_r, row_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              start_emit;
  logic              nz_sel;
  logic [3:0]        last_term;
  logic [1:0]        p_col;
  logic [1:0]        q_col;
  vmt_pkg::bsel_t    r_pq;
  vmt_pkg::bsel_t    r_qp;
  logic [1:0]        sub;
  logic [1:0]        hi;

  function automatic vmt_pkg::bsel_t mv_sel(logic [1:0] k);
    case (k)
      2'd0:    return vmt_pkg::B_MV0;
      2'd1:    return vmt_pkg::B_MV1;
      default: return vmt_pkg::B_MV2;
    endcase
  endfunction

  always_comb begin
    case (axis_r)
      2'd0:    nz_sel = angle_nz[0];
      2'd1:    nz_sel = angle_nz[1];
      2'd2:    nz_sel = angle_nz[2];
      default: nz_sel = 1'b0;
    endcase
    last_term = (op_r == vmt_pkg::OP_LOCAL) ? vmt_pkg::LOCAL_LAST : vmt_pkg::FULL_LAST;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    axis_nxt      = axis_r;
    term_nxt      = term_r;
    drain_nxt     = drain_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    start_emit    = 1'b0;
    emit          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = vmt_pkg::opcode_t'(in_opcode);
          term_nxt = '0;
          axis_nxt = '0;
          case (in_opcode)
            vmt_pkg::OP_LOCAL, vmt_pkg::OP_WORLD: state_nxt = S_RUN;
            vmt_pkg::OP_ROTATE:                   state_nxt = S_AXIS;
            default:                              start_emit = 1'b1;
          endcase
        end
      end
      S_AXIS: begin
        if (axis_r == AXIS_DONE) begin
          start_emit = 1'b1;
        end else if (nz_sel) begin
          term_nxt  = '0;
          state_nxt = S_RUN;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_RUN: begin
        if (term_r == last_term) begin
          drain_nxt = '0;
          state_nxt = S_DRAIN;
        end else begin
          term_nxt = term_r + 4'd1;
        end
      end
      S_DRAIN: begin
        if (drain_r == DRAIN_LAST) begin
          if (op_r == vmt_pkg::OP_ROTATE) begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_AXIS;
          end else begin
            start_emit = 1'b1;
          end
        end else begin
          drain_nxt = drain_r + 2'd1;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (row_r == vmt_pkg::LAST_ROW) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            row_nxt   = row_r + 2'd1;
            emit.load = 1'b1;
            emit.row  = row_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (start_emit) begin
      state_nxt     = S_EMIT;
      out_valid_nxt = 1'b1;
      row_nxt       = '0;
      emit.load     = 1'b1;
      emit.row      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= vmt_pkg::OP_LOCAL;
      axis_r      <= '0;
      term_r      <= '0;
      drain_r     <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      axis_r      <= axis_nxt;
      term_r      <= term_nxt;
      drain_r     <= drain_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Rotation about one axis touches only columns p and q of each row.
  always_comb begin
    case (axis_r)
      2'd0: begin
        p_col = 2'd1;
        q_col = 2'd2;
        r_pq  = vmt_pkg::B_SIN;
        r_qp  = vmt_pkg::B_NSIN;
      end
      2'd1: begin
        p_col = 2'd0;
        q_col = 2'd2;
        r_pq  = vmt_pkg::B_NSIN;
        r_qp  = vmt_pkg::B_SIN;
      end
      default: begin
        p_col = 2'd0;
        q_col = 2'd1;
        r_pq  = vmt_pkg::B_SIN;
        r_qp  = vmt_pkg::B_NSIN;
      end
    endcase
  end

  always_comb begin
    sub        = term_r[1:0];
    hi         = term_r[3:2];
    term       = '0;
    term.b_sel = vmt_pkg::B_ONE;
    term.valid = (state_r == S_RUN);
    case (op_r)
      vmt_pkg::OP_LOCAL: begin
        if (!term_r[0]) begin
          term.a_idx = {vmt_pkg::LAST_ROW, term_r[2:1]};
          term.first = 1'b1;
        end else begin
          term.a_one = 1'b1;
          term.b_sel = mv_sel(term_r[2:1]);
          term.last  = 1'b1;
          term.dest  = {vmt_pkg::LAST_ROW, term_r[2:1]};
        end
      end
      vmt_pkg::OP_WORLD: begin
        term.a_idx = {sub, hi};
        term.b_sel = (sub == 2'd3) ? vmt_pkg::B_ONE : mv_sel(sub);
        term.first = (sub == 2'd0);
        term.last  = (sub == 2'd3);
        term.dest  = {vmt_pkg::LAST_ROW, hi};
      end
      default: begin
        case (sub)
          2'd0: begin
            term.a_idx = {hi, p_col};
            term.b_sel = vmt_pkg::B_COS;
            term.first = 1'b1;
          end
          2'd1: begin
            term.a_idx = {hi, q_col};
            term.b_sel = r_qp;
            term.last  = 1'b1;
            term.dest  = {hi, p_col};
          end
          2'd2: begin
            term.a_idx = {hi, p_col};
            term.b_sel = r_pq;
            term.first = 1'b1;
          end
          default: begin
            term.a_idx = {hi, q_col};
            term.b_sel = vmt_pkg::B_COS;
            term.last  = 1'b1;
            term.dest  = {hi, q_col};
          end
        endcase
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign axis      = axis_r;

  `VMT_ASSERT_IMPL(a_valid_in_emit, clk, rst_n, out_valid_r, state_r == S_EMIT, "output word valid outside emit")
  `VMT_ASSERT_IMPL(a_axis_rotate, clk, rst_n, state_r == S_AXIS, op_r == vmt_pkg::OP_ROTATE, "axis walk for a non-rotate opcode")
  `VMT_ASSERT_IMPL(a_local_terms, clk, rst_n, (state_r == S_RUN) && (op_r == vmt_pkg::OP_LOCAL), term_r <= vmt_pkg::LOCAL_LAST, "local translate ran past its terms")
  `VMT_ASSERT_NEXT(a_last_row_done, clk, rst_n, out_valid_r && !out_stall && (row_r == vmt_pkg::LAST_ROW), !out_valid_r && (state_r == S_IDLE), "block not idle after the last row")

endmodule

// File: sv/view_matrix_transform_unit.sv
// Top level of the view matrix transform unit: matrix registers, operand
// selection, and the output word register. Uses vmt_pkg, vmt_seq, vmt_mac
// and vmt_sincos_rom.
//
// Usage: one input word carries an opcode, three Q16.16 moves and three angles
// in tenths of a degree. Opcode 0 adds the moves to row 3, opcode 1 applies a
// world translation, opcode 2 applies up to three axis rotations, opcode 3
// changes nothing. Every input word produces four output words, rows 0 to 3 of
// the updated matrix, with last_row set on row 3.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. in_stall is high from the accepted input word until row 3 has been
// taken. While out_stall is high the current row is held unchanged.
// The shared 32x32 multiplier takes one product term per cycle, and a drain
// follows the last term before its results are used. Row 0 is presented when
// the last result of the opcode is in the matrix; opcode 2 skips each axis
// whose angle is zero. Each further row is presented once the row before it
// has been taken.
// Reset (synchronous, active low) loads the identity matrix and empties both
// channels; the sine/cosine table is constant and needs no fill.
module view_matrix_transform_unit #(
  parameter int ANGLE_STEPS   = vmt_pkg::ANGLE_STEPS_DEF,
  parameter int FRACTION_BITS = vmt_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_move_x,
  input  logic signed [31:0] in_move_y,
  input  logic signed [31:0] in_move_z,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_elem_0,
  output logic signed [31:0] out_elem_1,
  output logic signed [31:0] out_elem_2,
  output logic signed [31:0] out_elem_3,
  output logic               out_last_row
);

  localparam int EW = vmt_pkg::ELEM_W;
  localparam int AW = vmt_pkg::ANGLE_W;
  localparam logic signed [EW-1:0] FIX_ONE = EW'(64'd1 << FRACTION_BITS);
  localparam logic signed [16:0]   TURN_S  = 17'(vmt_pkg::TENTHS_PER_TURN);

  logic signed [EW-1:0] mat_r [4][4];
  logic signed [EW-1:0] mv_r [3];
  logic [AW-1:0]        ang_r [3];
  logic [1:0]           out_row_r;
  logic signed [EW-1:0] out_elem_r [4];

  logic                 in_acc;
  logic [2:0]           angle_nz;
  logic [1:0]           axis;
  logic [AW-1:0]        rom_addr;
  logic signed [EW-1:0] sin_q;
  logic signed [EW-1:0] cos_q;
  logic signed [EW-1:0] op_a;
  logic signed [EW-1:0] op_b;
  vmt_pkg::term_t       term;
  vmt_pkg::emit_t       emit;
  vmt_pkg::mac_tag_t    tag;
  vmt_pkg::mat_wr_t     wr;

  // A negative angle wraps by one turn; anything still outside a turn is zero.
  function automatic logic [AW-1:0] norm_angle(logic signed [15:0] a);
    logic signed [16:0] w;
    w = 17'(a);
    if (w < 17'sd0) begin
      w = w + TURN_S;
    end
    if (w < 17'sd0 || w > TURN_S) begin
      return '0;
    end
    return w[AW-1:0];
  endfunction

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mv_r[0]  <= in_move_x;
      mv_r[1]  <= in_move_y;
      mv_r[2]  <= in_move_z;
      ang_r[0] <= norm_angle(in_angle_x);
      ang_r[1] <= norm_angle(in_angle_y);
      ang_r[2] <= norm_angle(in_angle_z);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      angle_nz[k] = (ang_r[k] != '0);
    end
    case (axis)
      2'd0:    rom_addr = ang_r[0];
      2'd1:    rom_addr = ang_r[1];
      2'd2:    rom_addr = ang_r[2];
      default: rom_addr = '0;
    endcase
  end

  vmt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .angle_nz  (angle_nz),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .axis      (axis),
    .term      (term),
    .emit      (emit)
  );

  vmt_sincos_rom #(
    .ANGLE_STEPS   (ANGLE_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_rom (
    .clk   (clk),
    .addr  (rom_addr),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  always_comb begin
    op_a = term.a_one ? FIX_ONE : mat_r[term.a_idx[3:2]][term.a_idx[1:0]];
    case (term.b_sel)
      vmt_pkg::B_ONE:  op_b = FIX_ONE;
      vmt_pkg::B_COS:  op_b = cos_q;
      vmt_pkg::B_SIN:  op_b = sin_q;
      vmt_pkg::B_NSIN: op_b = -sin_q;
      vmt_pkg::B_MV0:  op_b = mv_r[0];
      vmt_pkg::B_MV1:  op_b = mv_r[1];
      vmt_pkg::B_MV2:  op_b = mv_r[2];
      default:         op_b = '0;
    endcase
    tag.valid = term.valid;
    tag.first = term.first;
    tag.last  = term.last;
    tag.dest  = term.dest;
  end

  vmt_mac #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .tag   (tag),
    .op_a  (op_a),
    .op_b  (op_b),
    .wr    (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat_r[r][c] <= (r == c) ? FIX_ONE : '0;
        end
      end
    end else if (wr.en) begin
      mat_r[wr.addr[3:2]][wr.addr[1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_row_r <= emit.row;
      for (int c = 0; c < 4; c++) begin
        out_elem_r[c] <= mat_r[emit.row][c];
      end
    end
  end

  assign out_row_index = out_row_r;
  assign out_elem_0    = out_elem_r[0];
  assign out_elem_1    = out_elem_r[1];
  assign out_elem_2    = out_elem_r[2];
  assign out_elem_3    = out_elem_r[3];
  assign out_last_row  = (out_row_r == vmt_pkg::LAST_ROW);

endmodule
